// ----- src/tgi_pkg.sv -----
// Shared constants for the trilinear grid interpolator.
// No dependencies; used by tgi_in_if, the core and the testbench.
package tgi_pkg;

    localparam int unsigned DEF_GRID_X    = 64;
    localparam int unsigned DEF_GRID_Y    = 64;
    localparam int unsigned DEF_GRID_Z    = 64;
    localparam int unsigned DEF_FRAC_BITS = 16;

    localparam int unsigned ADDR_W      = 18;
    localparam int unsigned STORE_DEPTH = 262144;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'h0001_0000;

endpackage

// ----- src/tgi_in_if.sv -----
// Input channel of the interpolator: valid/ready plus one item.
// Depends on tgi_pkg for field widths.
interface tgi_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [tgi_pkg::ADDR_W-1:0]    voxel_address;
    logic signed [31:0]            voxel_value;
    logic signed [31:0]            point_x;
    logic signed [31:0]            point_y;
    logic signed [31:0]            point_z;

    modport source (output valid, op, voxel_address, voxel_value, point_x, point_y, point_z,
                    input ready);
    modport sink   (input valid, op, voxel_address, voxel_value, point_x, point_y, point_z,
                    output ready);
endinterface

// ----- src/tgi_out_if.sv -----
// Output channel of the interpolator: valid/ready plus one result.
// No dependencies.
interface tgi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               outside;

    modport source (output valid, value, outside, input ready);
    modport sink   (input valid, value, outside, output ready);
endinterface

// ----- src/tgi_ram.sv -----
// Generic single-port RAM with registered read and a clock enable.
// No dependencies.
module tgi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- src/trilinear_grid_interpolator_core.sv -----
// Trilinear interpolator over a voxel grid held in eight replicated RAMs.
// Depends on tgi_pkg, tgi_in_if, tgi_out_if and tgi_ram.
// Throughput is one beat per cycle while no result waits at the output.
// The whole pipeline freezes while a result waits at the output; writes give no beat.
// Eight RAM copies, each written by every store beat, give eight corner reads a cycle.
// Reset clears valid bits and sets registers to their defaults; the store is not cleared.
module trilinear_grid_interpolator_core #(
    parameter int unsigned GRID_X    = tgi_pkg::DEF_GRID_X,
    parameter int unsigned GRID_Y    = tgi_pkg::DEF_GRID_Y,
    parameter int unsigned GRID_Z    = tgi_pkg::DEF_GRID_Z,
    parameter int unsigned FRAC_BITS = tgi_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tgi_in_if.sink                        in_ch,
    tgi_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [tgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgi_pkg::DATA_W-1:0]    cfg_data
);
    import tgi_pkg::*;

    localparam int unsigned GMAX = (GRID_X > GRID_Y) ?
        ((GRID_X > GRID_Z) ? GRID_X : GRID_Z) : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
    localparam int unsigned IW = $clog2(GMAX);
    localparam int unsigned PW = 33 + FRAC_BITS;
    localparam int unsigned WW = FRAC_BITS + 1;
    localparam logic [31:0] LAST [3] = '{32'(GRID_X - 1), 32'(GRID_Y - 1), 32'(GRID_Z - 1)};
    localparam logic [ADDR_W-1:0] MUL_Y = ADDR_W'(GRID_Y);
    localparam logic [ADDR_W-1:0] MUL_Z = ADDR_W'(GRID_Z);

    function automatic logic signed [PW-1:0] wmul(input logic [31:0] a, input logic [WW-1:0] w);
        logic signed [PW-1:0] ae;
        logic signed [PW-1:0] we_;
        ae  = $signed({{(PW-32){a[31]}}, a});
        we_ = $signed({{(PW-WW){1'b0}}, w});
        return ae * we_;
    endfunction

    function automatic logic [31:0] wsum(input logic signed [PW-1:0] p, input logic signed [PW-1:0] q);
        logic signed [PW-1:0] s;
        s = (p + q) >>> FRAC_BITS;
        return s[31:0];
    endfunction

    // Configuration registers.
    logic [31:0] origin_reg [3];
    logic [31:0] inv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                origin_reg[a] <= '0;
                inv_reg[a]    <= INV_STEP_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:   origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:   origin_reg[2] <= cfg_data;
                REG_INV_STEP_X: inv_reg[0]    <= cfg_data;
                REG_INV_STEP_Y: inv_reg[1]    <= cfg_data;
                REG_INV_STEP_Z: inv_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage moves together; only a held result at the output stops them.
    logic adv;
    logic out_valid_reg;
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Valid and op bits, stages 1..10.
    logic [10:1] v_reg;
    logic [10:1] op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[9:1], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            op_reg <= {op_reg[9:1], in_ch.op};
    end

    // Store beats ride along with queries so that order is kept at the RAM.
    logic [ADDR_W-1:0] waddr_reg [1:4];
    logic [31:0]       wdata_reg [1:4];

    // Stage 1: difference to the origin.
    logic signed [32:0] diff_reg [3];
    // Stage 2: full Q32.32 coefficient.
    logic [63:0]        prod_reg [3];
    logic [2:0]         below_reg;
    // Stage 3: indices and weights.
    logic [IW-1:0]      lo_reg [3];
    logic [IW-1:0]      hi_reg [3];
    logic [FRAC_BITS-1:0] frac_reg [3][3:9];
    logic               out3_reg;
    logic [10:4]        outf_reg;
    // Stage 4: corner addresses.
    logic [ADDR_W-1:0]  caddr_reg [8];

    logic signed [32:0] diff_next [3];
    logic [63:0]        prod_next [3];
    logic [2:0]         below_next;
    logic [2:0]         above_next;
    logic [IW-1:0]      lo_next [3];
    logic [IW-1:0]      hi_next [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic [31:0] p;
            logic [31:0] upper;
            p = (a == 0) ? in_ch.point_x : ((a == 1) ? in_ch.point_y : in_ch.point_z);
            diff_next[a] = $signed({p[31], p}) - $signed({origin_reg[a][31], origin_reg[a]});
            below_next[a] = diff_reg[a][32] && (inv_reg[a] != '0);
            prod_next[a]  = diff_reg[a][32] ? 64'd0 : (64'(diff_reg[a][31:0]) * 64'(inv_reg[a]));
            upper = prod_reg[a][63:32];
            above_next[a] = (upper > LAST[a]) || ((upper == LAST[a]) && (prod_reg[a][31:0] != '0));
            lo_next[a] = upper[IW-1:0];
            hi_next[a] = (upper == LAST[a]) ? upper[IW-1:0] : IW'(upper + 32'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            waddr_reg[1] <= in_ch.voxel_address;
            wdata_reg[1] <= in_ch.voxel_value;
            for (int s = 2; s <= 4; s++)
            begin
                waddr_reg[s] <= waddr_reg[s-1];
                wdata_reg[s] <= wdata_reg[s-1];
            end
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= diff_next[a];
                prod_reg[a] <= prod_next[a];
                lo_reg[a]   <= lo_next[a];
                hi_reg[a]   <= hi_next[a];
                frac_reg[a][3] <= prod_reg[a][31:32-FRAC_BITS];
                for (int s = 4; s <= 9; s++)
                    frac_reg[a][s] <= frac_reg[a][s-1];
            end
            below_reg <= below_next;
            out3_reg  <= (|below_reg) || (|above_next);
            outf_reg  <= {outf_reg[9:4], out3_reg};
            for (int k = 0; k < 8; k++)
            begin
                logic [ADDR_W-1:0] ix;
                logic [ADDR_W-1:0] iy;
                logic [ADDR_W-1:0] iz;
                ix = ADDR_W'(k[2] ? hi_reg[0] : lo_reg[0]);
                iy = ADDR_W'(k[1] ? hi_reg[1] : lo_reg[1]);
                iz = ADDR_W'(k[0] ? hi_reg[2] : lo_reg[2]);
                caddr_reg[k] <= (ix * MUL_Y + iy) * MUL_Z + iz;
            end
        end
    end

    // Stage 5: RAM access; each copy reads one corner or takes the store beat.
    logic        ram_we;
    logic [31:0] corner [8];
    assign ram_we = v_reg[4] && (op_reg[4] == OP_WRITE);

    for (genvar k = 0; k < 8; k++)
    begin : g_bank
        tgi_ram #(
            .WIDTH (DATA_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (adv),
            .we    (ram_we),
            .addr  (ram_we ? waddr_reg[4] : caddr_reg[k]),
            .wdata (wdata_reg[4]),
            .rdata (corner[k])
        );
    end

    // Stages 6..10 and the output register: products, then sums, along x, y and z.
    logic signed [PW-1:0] xp_reg [4][2];
    logic [31:0]          xc_reg [4];
    logic signed [PW-1:0] yp_reg [2][2];
    logic [31:0]          yc_reg [2];
    logic signed [PW-1:0] zp_reg [2];
    logic [31:0]          value_reg;
    logic                 outside_reg;

    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                // Pair k holds corners with the same y and z, x low then high.
                xp_reg[k][0] <= wmul(corner[k], ONE - WW'(frac_reg[0][5]));
                xp_reg[k][1] <= wmul(corner[k+4], WW'(frac_reg[0][5]));
                xc_reg[k]    <= wsum(xp_reg[k][0], xp_reg[k][1]);
            end
            for (int k = 0; k < 2; k++)
            begin
                yp_reg[k][0] <= wmul(xc_reg[k], ONE - WW'(frac_reg[1][7]));
                yp_reg[k][1] <= wmul(xc_reg[k+2], WW'(frac_reg[1][7]));
                yc_reg[k]    <= wsum(yp_reg[k][0], yp_reg[k][1]);
            end
            zp_reg[0] <= wmul(yc_reg[0], ONE - WW'(frac_reg[2][9]));
            zp_reg[1] <= wmul(yc_reg[1], WW'(frac_reg[2][9]));
            value_reg   <= outf_reg[10] ? 32'd0 : wsum(zp_reg[0], zp_reg[1]);
            outside_reg <= outf_reg[10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[10] && (op_reg[10] == OP_QUERY);
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.value   = value_reg;
    assign out_ch.outside = outside_reg;

`ifndef SYNTH
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && outside_reg |-> value_reg == 32'd0)
        else $error("outside result carries a nonzero value");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[10] && (op_reg[10] == OP_WRITE) |=> !out_valid_reg)
        else $error("store beat produced a result");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during a stall");
`endif
endmodule

// ----- bench/trilinear_grid_interpolator_core_test.sv -----
// Testbench for trilinear_grid_interpolator_core: it predicts each query from its own grid copy.
// Depends on tgi_pkg, tgi_in_if, tgi_out_if and the core RTL.
`timescale 1ns / 100ps

module trilinear_grid_interpolator_core_test;
    import tgi_pkg::*;

    localparam int unsigned GX = DEF_GRID_X;
    localparam int unsigned GY = DEF_GRID_Y;
    localparam int unsigned GZ = DEF_GRID_Z;
    localparam int unsigned FB = DEF_FRAC_BITS;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       sample;
        logic [31:0]       px;
        logic [31:0]       py;
        logic [31:0]       pz;
    } grid_item_t;

    typedef struct {
        logic [31:0] value;
        logic        outside;
    } interp_result_t;

    class InterpScoreboard;
        logic [31:0] voxels [int unsigned];
        logic [31:0] regs [6];
        interp_result_t pending_results[$];
        int failures;

        function new();
            failures = 0;
            regs[REG_ORIGIN_X] = '0;
            regs[REG_ORIGIN_Y] = '0;
            regs[REG_ORIGIN_Z] = '0;
            regs[REG_INV_STEP_X] = INV_STEP_RESET;
            regs[REG_INV_STEP_Y] = INV_STEP_RESET;
            regs[REG_INV_STEP_Z] = INV_STEP_RESET;
        endfunction

        // Finds the cell on one axis; coeff is exact in unsigned Q32.32.
        function bit locate_axis(logic [31:0] p, logic [31:0] org, logic [31:0] inv,
                                 int unsigned n, output int unsigned lo,
                                 output int unsigned hi, output logic [FB-1:0] frac);
            longint diff;
            logic [63:0] coeff;
            lo = 0;
            hi = 0;
            frac = '0;
            diff = longint'($signed(p)) - longint'($signed(org));
            if (diff < 0) begin
                if (inv != 0)
                    return 0;
                coeff = '0;
            end
            else
                coeff = 64'(diff) * 64'(inv);
            if (coeff > (64'(n - 1) << 32))
                return 0;
            lo = coeff[63:32];
            hi = (lo + 1 <= n - 1) ? lo + 1 : n - 1;
            frac = coeff[31:32-FB];
            return 1;
        endfunction

        function int unsigned grid_addr(int unsigned ix, int unsigned iy, int unsigned iz);
            longint unsigned a;
            a = (longint'(ix) * GY + iy) * GZ + iz;
            return a % STORE_DEPTH;
        endfunction

        // Linear addresses of the eight corners a query reads; returns 0 if it is outside.
        function bit corner_addrs(grid_item_t it, output int unsigned addrs[8]);
            int unsigned x[2], y[2], z[2];
            logic [FB-1:0] dx, dy, dz;
            bit in_grid;
            in_grid = locate_axis(it.px, regs[REG_ORIGIN_X], regs[REG_INV_STEP_X], GX,
                                  x[0], x[1], dx);
            in_grid = locate_axis(it.py, regs[REG_ORIGIN_Y], regs[REG_INV_STEP_Y], GY,
                                  y[0], y[1], dy) && in_grid;
            in_grid = locate_axis(it.pz, regs[REG_ORIGIN_Z], regs[REG_INV_STEP_Z], GZ,
                                  z[0], z[1], dz) && in_grid;
            for (int k = 0; k < 8; k++)
                addrs[k] = grid_addr(x[k[2]], y[k[1]], z[k[0]]);
            return in_grid;
        endfunction

        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [FB-1:0] d);
            longint s;
            longint r;
            s = longint'($signed(a)) * ((longint'(1) << FB) - longint'(d))
                + longint'($signed(b)) * longint'(d);
            r = s >>> FB;
            return r[31:0];
        endfunction

        function void note_input(grid_item_t it);
            int unsigned x[2], y[2], z[2];
            logic [FB-1:0] dx, dy, dz;
            logic [31:0] c[8];
            logic [31:0] c00, c01, c10, c11;
            interp_result_t res;
            bit in_grid;
            if (it.op == OP_WRITE) begin
                voxels[it.addr] = it.sample;
                return;
            end
            in_grid = locate_axis(it.px, regs[REG_ORIGIN_X], regs[REG_INV_STEP_X], GX,
                                  x[0], x[1], dx);
            in_grid = locate_axis(it.py, regs[REG_ORIGIN_Y], regs[REG_INV_STEP_Y], GY,
                                  y[0], y[1], dy) && in_grid;
            in_grid = locate_axis(it.pz, regs[REG_ORIGIN_Z], regs[REG_INV_STEP_Z], GZ,
                                  z[0], z[1], dz) && in_grid;
            if (!in_grid) begin
                res.value = '0;
                res.outside = 1'b1;
            end
            else begin
                // Index bits are x, y, z from high to low.
                for (int k = 0; k < 8; k++)
                    c[k] = voxels[grid_addr(x[k[2]], y[k[1]], z[k[0]])];
                c00 = blend(c[0], c[4], dx);
                c01 = blend(c[1], c[5], dx);
                c10 = blend(c[2], c[6], dx);
                c11 = blend(c[3], c[7], dx);
                res.value = blend(blend(c00, c10, dy), blend(c01, c11, dy), dz);
                res.outside = 1'b0;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [31:0] value, logic outside);
            interp_result_t want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: value=%h outside=%b", value, outside);
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value || outside !== want.outside) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: expected value=%h outside=%b, got value=%h outside=%b",
                             want.value, want.outside, value, outside);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;
    bit quiet;
    int cycle_count;
    int ready_hold;
    InterpScoreboard sb;

    tgi_in_if in_ch();
    tgi_out_if out_ch();

    trilinear_grid_interpolator_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("trilinear_grid_interpolator_core_test failed");
            $finish;
        end
    end

    // Result side: check each beat, then stall in short random bursts unless quiet is set.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.value, out_ch.outside);
        if (quiet)
            out_ch.ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(1, 4) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic send_beat(grid_item_t it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.voxel_address <= it.addr;
        in_ch.voxel_value <= it.sample;
        in_ch.point_x <= it.px;
        in_ch.point_y <= it.py;
        in_ch.point_z <= it.pz;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(it);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_write(int unsigned addr, logic [31:0] sample);
        grid_item_t it;
        it.op = OP_WRITE;
        it.addr = ADDR_W'(addr);
        it.sample = sample;
        it.px = $urandom();
        it.py = $urandom();
        it.pz = $urandom();
        send_beat(it);
    endtask

    // Writes any corner the query would read that holds no sample yet, then sends it.
    task automatic send_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        grid_item_t it;
        int unsigned addrs[8];
        it.op = OP_QUERY;
        it.addr = ADDR_W'($urandom());
        it.sample = $urandom();
        it.px = px;
        it.py = py;
        it.pz = pz;
        if (sb.corner_addrs(it, addrs))
            foreach (addrs[k])
                if (!sb.voxels.exists(addrs[k]))
                    send_write(addrs[k], rand_sample());
        send_beat(it);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        logic [31:0] vals[6];
        vals = '{ox, oy, oz, sx, sy, sz};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.regs[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    // A coordinate aimed at grid position t (Q16.16, a little beyond both ends).
    function automatic logic [31:0] aim_axis(int idx);
        longint t;
        longint p;
        longint inv;
        inv = longint'(sb.regs[REG_INV_STEP_X + idx]);
        if (inv == 0)
            return $urandom();
        case ($urandom_range(0, 7))
            0: t = longint'($urandom_range(0, 63)) <<< 16;
            1: t = longint'(63) <<< 16;
            default: t = longint'($urandom_range(0, 68 * 65536)) - 2 * 65536;
        endcase
        p = longint'($signed(sb.regs[REG_ORIGIN_X + idx])) + (t <<< 16) / inv;
        if (p > 64'sh7FFF_FFFF)
            p = 64'sh7FFF_FFFF;
        if (p < -64'sh8000_0000)
            p = -64'sh8000_0000;
        return p[31:0];
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_write($urandom_range(0, STORE_DEPTH - 1), rand_sample());
                2: send_query($urandom(), $urandom(), $urandom());
                default: send_query(aim_axis(0), aim_axis(1), aim_axis(2));
            endcase
            // Hold the sender once until the pipeline has fully drained.
            if (i == n / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        ready_hold = 0;
        cycle_count = 0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_WRITE;
        in_ch.voxel_address = '0;
        in_ch.voxel_value = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: extremes, last plane, both sides outside.
        send_write(0, 32'h8000_0000);
        send_write(STORE_DEPTH - 1, 32'h7FFF_FFFF);
        send_write(1, 32'h7FFF_FFFF);
        send_write(GZ, 32'h7FFF_FFFF);
        send_query(32'h0, 32'h0, 32'h0);
        send_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_query(32'h0000_FFFF, 32'h0000_0001, 32'h0000_7FFF);
        send_query(32'h003F_0000, 32'h003F_0000, 32'h003F_0000);
        send_query(32'h003F_0001, 32'h0010_0000, 32'h0010_0000);
        send_query(32'h0010_0000, 32'hFFFF_FFFF, 32'h0010_0000);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'h003E_FFFF, 32'h0000_0000, 32'h003F_0000);
        wait_idle();

        // Zero reciprocal on x, extreme origins and steps elsewhere.
        program_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0012_3456,
                     32'h0, 32'hFFFF_FFFF, 32'h0000_4000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0012_3456);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0013_0000);
        random_phase(14);

        program_grid(32'hFFF0_0000, 32'h0, 32'h7FFF_FFFF,
                     32'h0000_1000, 32'h0010_0000, 32'h0001_0000);
        random_phase(14);

        program_grid($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                     $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                     $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                     $urandom_range(32'h400, 32'h8_0000),
                     $urandom_range(32'h400, 32'h8_0000),
                     $urandom_range(32'h400, 32'h8_0000));
        random_phase(14);

        program_grid(32'h0, 32'h0, 32'h0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET);
        random_phase(14);

        quiet = 1'b1;
        random_phase(14);

        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("trilinear_grid_interpolator_core_test passed");
        else
            $display("trilinear_grid_interpolator_core_test failed");
        $finish;
    end
endmodule
